// File: sv/yfps_pkg.sv
`timescale 1ns / 1ps
package yfps_pkg;

  localparam int DEF_MAX_WIDTH          = 4096;
  localparam int DEF_MAX_HEIGHT         = 4096;
  localparam int DEF_MEAN_FRACTION_BITS = 8;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int SIZE_W    = 13;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 2 * SIZE_W;
  localparam int MEAN_W    = 16;
  localparam int NUM_PLANE = 3;

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(1080);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_CHROMA_SHIFT_H = 2'd2,
    REG_CHROMA_SHIFT_V = 2'd3
  } yfps_reg_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } yfps_plane_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_CHECK,
    BK_DIV,
    BK_STORE,
    BK_EMIT
  } yfps_back_state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic              chroma_shift_h;
    logic              chroma_shift_v;
  } yfps_cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb_sample;
    logic [7:0] cr_sample;
  } yfps_pixel_t;

  typedef struct packed {
    logic [31:0]       frame_number;
    logic [7:0]        min_y;
    logic [MEAN_W-1:0] mean_y;
    logic [7:0]        max_y;
    logic [7:0]        min_u;
    logic [MEAN_W-1:0] mean_u;
    logic [7:0]        max_u;
    logic [7:0]        min_v;
    logic [MEAN_W-1:0] mean_v;
    logic [7:0]        max_v;
  } yfps_result_t;

  // Frame totals handed from the front to the divider side
  typedef struct packed {
    logic [31:0]                     frame_number;
    logic [NUM_PLANE-1:0][7:0]       minimum;
    logic [NUM_PLANE-1:0][7:0]       maximum;
    logic [NUM_PLANE-1:0][SUM_W-1:0] sum;
    logic [SIZE_W-1:0]               width;
    logic [SIZE_W-1:0]               height;
    logic [SIZE_W-1:0]               chroma_width;
    logic [SIZE_W-1:0]               chroma_height;
  } yfps_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } yfps_queue_status_t;

endpackage

// File: sv/yfps_front.sv
`timescale 1ns / 1ps
module yfps_front #(
  parameter int MAX_WIDTH  = yfps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yfps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  yfps_pkg::yfps_cfg_t  cfg_i,
  input  logic                 accept_i,
  input  yfps_pkg::yfps_pixel_t pixel_i,
  output logic                 snap_push_o,
  output yfps_pkg::yfps_snap_t snap_o
);
  import yfps_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [31:0]     frame_q, frame_d;
  logic [NUM_PLANE-1:0][7:0]       min_q, min_d, min_n;
  logic [NUM_PLANE-1:0][7:0]       max_q, max_d, max_n;
  logic [NUM_PLANE-1:0][SUM_W-1:0] sum_q, sum_d, sum_n;
  logic [NUM_PLANE-1:0][7:0]       smp;
  logic [NUM_PLANE-1:0]            en;

  logic [SIZE_W-1:0] w, h, cw, ch;
  logic [SIZE_W:0]   col_next, row_next;
  logic              chroma_en, col_last, row_last, frame_end;

  always_comb begin
    // Zero counts as one; anything past the maximum is held at the maximum
    if (cfg_i.frame_width == '0) begin
      w = SIZE_W'(1);
    end else if ({1'b0, cfg_i.frame_width} > (SIZE_W + 1)'(MAX_WIDTH)) begin
      w = SIZE_W'(MAX_WIDTH);
    end else begin
      w = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      h = SIZE_W'(1);
    end else if ({1'b0, cfg_i.frame_height} > (SIZE_W + 1)'(MAX_HEIGHT)) begin
      h = SIZE_W'(MAX_HEIGHT);
    end else begin
      h = cfg_i.frame_height;
    end
    cw = w >> cfg_i.chroma_shift_h;
    ch = h >> cfg_i.chroma_shift_v;

    chroma_en = (SIZE_W'(col_q) < cw) && (SIZE_W'(row_q) < ch);
    col_next  = (SIZE_W + 1)'(col_q) + (SIZE_W + 1)'(1);
    row_next  = (SIZE_W + 1)'(row_q) + (SIZE_W + 1)'(1);
    col_last  = col_next >= {1'b0, w};
    row_last  = row_next >= {1'b0, h};
    frame_end = accept_i && col_last && row_last;

    smp[PLANE_Y] = pixel_i.luma;
    smp[PLANE_U] = pixel_i.cb_sample;
    smp[PLANE_V] = pixel_i.cr_sample;
    en[PLANE_Y]  = 1'b1;
    en[PLANE_U]  = chroma_en;
    en[PLANE_V]  = chroma_en;

    for (int p = 0; p < NUM_PLANE; p++) begin
      min_n[p] = (en[p] && (smp[p] < min_q[p])) ? smp[p] : min_q[p];
      max_n[p] = (en[p] && (smp[p] > max_q[p])) ? smp[p] : max_q[p];
      sum_n[p] = en[p] ? sum_q[p] + SUM_W'(smp[p]) : sum_q[p];
    end

    col_d   = col_q;
    row_d   = row_q;
    frame_d = frame_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : RowW'(row_next);
      end else begin
        col_d = ColW'(col_next);
      end
      if (frame_end) begin
        frame_d = frame_q + 32'd1;
        for (int p = 0; p < NUM_PLANE; p++) begin
          min_d[p] = 8'hFF;
          max_d[p] = 8'h00;
          sum_d[p] = '0;
        end
      end else begin
        min_d = min_n;
        max_d = max_n;
        sum_d = sum_n;
      end
    end
  end

  always_comb begin
    snap_push_o          = frame_end;
    snap_o.frame_number  = frame_q;
    snap_o.minimum       = min_n;
    snap_o.maximum       = max_n;
    snap_o.sum           = sum_n;
    snap_o.width         = w;
    snap_o.height        = h;
    snap_o.chroma_width  = cw;
    snap_o.chroma_height = ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
      for (int p = 0; p < NUM_PLANE; p++) begin
        min_q[p] <= 8'hFF;
        max_q[p] <= 8'h00;
        sum_q[p] <= '0;
      end
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      frame_q <= frame_d;
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// File: sv/yfps_queue.sv
`timescale 1ns / 1ps
module yfps_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  yfps_pkg::yfps_snap_t         data_i,
  input  logic                         pop_i,
  output yfps_pkg::yfps_snap_t         data_o,
  output yfps_pkg::yfps_queue_status_t status_o
);
  import yfps_pkg::*;

  yfps_snap_t  mem [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  always_comb begin
    status_o.full  = cnt_q == 2'd2;
    status_o.empty = cnt_q == 2'd0;
    do_push = push_i && !status_o.full;
    do_pop  = pop_i && !status_o.empty;
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
    data_o = mem[rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/yfps_back.sv
`timescale 1ns / 1ps
module yfps_back #(
  parameter int MEAN_FRACTION_BITS = yfps_pkg::DEF_MEAN_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_empty_i,
  input  yfps_pkg::yfps_snap_t  snap_i,
  output logic                  snap_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output yfps_pkg::yfps_result_t result_o
);
  import yfps_pkg::*;

  localparam int DivW = SUM_W + MEAN_FRACTION_BITS;
  localparam int HiW  = DivW - MEAN_W;
  localparam int RemW = CNT_W + 1;
  localparam int CmpW = (HiW > CNT_W) ? HiW : CNT_W;

  yfps_back_state_e state_q, state_d;

  logic do_take, do_load, do_check, do_step, do_store, do_emit;
  logic out_free;

  yfps_snap_t        snap_q;
  logic [1:0]        plane_q;
  logic [CNT_W-1:0]  count_q;
  logic [DivW-1:0]   dividend_q;
  logic [RemW-1:0]   rem_q;
  logic [MEAN_W-1:0] lo_q;
  logic [MEAN_W-1:0] quo_q;
  logic [3:0]        step_q;
  logic [NUM_PLANE-1:0][MEAN_W-1:0] mean_q;
  yfps_result_t      out_q;
  logic              out_valid_q;

  logic              count_zero, saturate;
  logic [RemW:0]     rem_shift;
  logic              rem_ge;

  always_comb begin
    out_free   = !out_valid_q || pop_i;
    count_zero = count_q == '0;
    saturate   = CmpW'(dividend_q[DivW-1:MEAN_W]) >= CmpW'(count_q);
    rem_shift  = {rem_q, lo_q[MEAN_W-1]};
    rem_ge     = rem_shift >= (RemW + 1)'(count_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (!snap_empty_i) state_d = BK_LOAD;
      BK_LOAD:  state_d = BK_CHECK;
      BK_CHECK: state_d = (count_zero || saturate) ? BK_STORE : BK_DIV;
      BK_DIV:   if (step_q == 4'd0) state_d = BK_STORE;
      BK_STORE: state_d = (plane_q == PLANE_V) ? BK_EMIT : BK_LOAD;
      BK_EMIT:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    do_take  = 1'b0;
    do_load  = 1'b0;
    do_check = 1'b0;
    do_step  = 1'b0;
    do_store = 1'b0;
    do_emit  = 1'b0;
    case (state_q)
      BK_IDLE:  do_take  = !snap_empty_i;
      BK_LOAD:  do_load  = 1'b1;
      BK_CHECK: do_check = 1'b1;
      BK_DIV:   do_step  = 1'b1;
      BK_STORE: do_store = 1'b1;
      BK_EMIT:  do_emit  = out_free;
      default:  do_take  = 1'b0;
    endcase
  end

  assign snap_pop_o = do_take;
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (do_take) begin
      snap_q <= snap_i;
    end
    if (do_load) begin
      if (plane_q == PLANE_Y) begin
        count_q <= CNT_W'(snap_q.width) * CNT_W'(snap_q.height);
      end else begin
        count_q <= CNT_W'(snap_q.chroma_width) * CNT_W'(snap_q.chroma_height);
      end
      dividend_q <= DivW'(snap_q.sum[plane_q]) << MEAN_FRACTION_BITS;
    end
    if (do_check) begin
      // Empty plane reads zero; a quotient past 16 bits saturates
      if (count_zero) begin
        quo_q <= '0;
      end else if (saturate) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
      end
      rem_q  <= RemW'(dividend_q[DivW-1:MEAN_W]);
      lo_q   <= dividend_q[MEAN_W-1:0];
      step_q <= 4'd15;
    end
    if (do_step) begin
      rem_q  <= rem_ge ? RemW'(rem_shift - (RemW + 1)'(count_q)) : RemW'(rem_shift);
      lo_q   <= {lo_q[MEAN_W-2:0], 1'b0};
      quo_q  <= {quo_q[MEAN_W-2:0], rem_ge};
      step_q <= step_q - 4'd1;
    end
    if (do_store) begin
      mean_q[plane_q] <= quo_q;
    end
    if (do_emit) begin
      out_q.frame_number <= snap_q.frame_number;
      out_q.min_y  <= snap_q.minimum[PLANE_Y];
      out_q.mean_y <= mean_q[PLANE_Y];
      out_q.max_y  <= snap_q.maximum[PLANE_Y];
      out_q.min_u  <= snap_q.minimum[PLANE_U];
      out_q.mean_u <= mean_q[PLANE_U];
      out_q.max_u  <= snap_q.maximum[PLANE_U];
      out_q.min_v  <= snap_q.minimum[PLANE_V];
      out_q.mean_v <= mean_q[PLANE_V];
      out_q.max_v  <= snap_q.maximum[PLANE_V];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      plane_q     <= PLANE_Y;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_take) begin
        plane_q <= PLANE_Y;
      end else if (do_store && plane_q != PLANE_V) begin
        plane_q <= plane_q + 2'd1;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: sv/yuv_frame_plane_statistics_unit.sv
`timescale 1ns / 1ps
// Per-frame minimum, mean and maximum of the Y, U and V planes of a raster pixel stream.
//
// Input: one pixel per request (luma, cb_sample, cr_sample), taken when push is high
// and full is low. The front takes one pixel every cycle while full is low and keeps
// column, row and frame counters plus running min, max and sum per plane; chroma counts
// only inside the subsampled chroma area.
// On the last pixel of a frame the totals go into a two-entry queue. The back side
// works out the three means with a shared shift-subtract divider, one quotient bit a
// cycle, and skips the division for an empty chroma plane or a saturated mean. full
// rises only when two frames are waiting in the queue; otherwise the block sustains
// one pixel a cycle.
// Results: the oldest result sits on out_data_o while empty is low; pop takes it.
// A stalled receiver holds one result in the output register, then the divider holds,
// then the queue fills and full rises.
// Configuration (APB, word registers): 0 frame_width, 1 frame_height,
// 2 chroma_shift_h, 3 chroma_shift_v. Write only while idle.
// Reset: 1920x1080 4:2:0, counters and accumulators cleared, no results waiting.
module yuv_frame_plane_statistics_unit #(
  parameter int MAX_WIDTH          = yfps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT         = yfps_pkg::DEF_MAX_HEIGHT,
  parameter int MEAN_FRACTION_BITS = yfps_pkg::DEF_MEAN_FRACTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [yfps_pkg::PADDR_W-1:0]    paddr,
  input  logic [yfps_pkg::PDATA_W-1:0]    pwdata,
  output logic [yfps_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            push,
  output logic                            full,
  input  yfps_pkg::yfps_pixel_t           in_data_i,
  output logic                            empty,
  input  logic                            pop,
  output yfps_pkg::yfps_result_t          out_data_o
);
  import yfps_pkg::*;

  yfps_cfg_t          cfg_q;
  yfps_reg_e          reg_idx;
  logic               cfg_wr;
  logic               accept;
  logic               snap_push, snap_pop;
  yfps_snap_t         snap_in, snap_out;
  yfps_queue_status_t q_status;

  assign pready  = 1'b1;
  assign reg_idx = yfps_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign full    = q_status.full;
  assign accept  = push && !q_status.full;

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:    prdata = PDATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:   prdata = PDATA_W'(cfg_q.frame_height);
      REG_CHROMA_SHIFT_H: prdata = PDATA_W'(cfg_q.chroma_shift_h);
      REG_CHROMA_SHIFT_V: prdata = PDATA_W'(cfg_q.chroma_shift_v);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= RST_FRAME_WIDTH;
      cfg_q.frame_height   <= RST_FRAME_HEIGHT;
      cfg_q.chroma_shift_h <= 1'b1;
      cfg_q.chroma_shift_v <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:    cfg_q.frame_width    <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[SIZE_W-1:0];
        REG_CHROMA_SHIFT_H: cfg_q.chroma_shift_h <= pwdata[0];
        REG_CHROMA_SHIFT_V: cfg_q.chroma_shift_v <= pwdata[0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  yfps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .pixel_i     (in_data_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  yfps_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (snap_push),
    .data_i   (snap_in),
    .pop_i    (snap_pop),
    .data_o   (snap_out),
    .status_o (q_status)
  );

  yfps_back #(
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_empty_i (q_status.empty),
    .snap_i       (snap_out),
    .snap_pop_o   (snap_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (out_data_o)
  );

endmodule

// File: verif/tb_yuv_frame_plane_statistics_unit.sv
`timescale 1ns / 1ps
module tb_yuv_frame_plane_statistics_unit;
  import yfps_pkg::*;

  localparam int unsigned MAX_W        = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H        = DEF_MAX_HEIGHT;
  localparam int unsigned FRAC_BITS    = DEF_MEAN_FRACTION_BITS;
  localparam int unsigned DRAIN_CYCLES = 100;

  class frame_stats_board;
    int unsigned  width_reg;
    int unsigned  height_reg;
    bit           shift_h;
    bit           shift_v;
    int unsigned  col;
    int unsigned  row;
    logic [31:0]  frame_no;
    int unsigned  min_s [NUM_PLANE];
    int unsigned  max_s [NUM_PLANE];
    int unsigned  sum_s [NUM_PLANE];
    yfps_result_t stats_due [$];
    int unsigned  mismatches;
    int unsigned  frames_checked;
    int unsigned  pixels_taken;

    function new();
      width_reg      = RST_FRAME_WIDTH;
      height_reg     = RST_FRAME_HEIGHT;
      shift_h        = 1'b1;
      shift_v        = 1'b1;
      col            = 0;
      row            = 0;
      frame_no       = '0;
      mismatches     = 0;
      frames_checked = 0;
      pixels_taken   = 0;
      clear_planes();
    endfunction

    function void clear_planes();
      for (int p = 0; p < NUM_PLANE; p++) begin
        min_s[p] = 255;
        max_s[p] = 0;
        sum_s[p] = 0;
      end
    endfunction

    function int unsigned limit_size(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function logic [MEAN_W-1:0] mean_fix(int unsigned sum, longint unsigned count);
      longint unsigned wide;
      longint unsigned q;
      if (count == 0) return '0;
      wide = sum;
      q = (wide << FRAC_BITS) / count;
      if (q > 64'hFFFF) q = 64'hFFFF;
      return q[MEAN_W-1:0];
    endfunction

    function int unsigned reg_value(yfps_reg_e idx);
      case (idx)
        REG_FRAME_WIDTH:    return width_reg;
        REG_FRAME_HEIGHT:   return height_reg;
        REG_CHROMA_SHIFT_H: return shift_h;
        default:            return shift_v;
      endcase
    endfunction

    function void write_reg(yfps_reg_e idx, int unsigned value);
      case (idx)
        REG_FRAME_WIDTH:    width_reg  = value & ((1 << SIZE_W) - 1);
        REG_FRAME_HEIGHT:   height_reg = value & ((1 << SIZE_W) - 1);
        REG_CHROMA_SHIFT_H: shift_h    = value[0];
        default:            shift_v    = value[0];
      endcase
    endfunction

    function void fold(int p, logic [7:0] v);
      if (v < min_s[p]) min_s[p] = v;
      if (v > max_s[p]) max_s[p] = v;
      sum_s[p] += v;
    endfunction

    function void take_pixel(yfps_pixel_t pix);
      int unsigned  w;
      int unsigned  h;
      int unsigned  cw;
      int unsigned  ch;
      bit           last;
      yfps_result_t r;
      w  = limit_size(width_reg, MAX_W);
      h  = limit_size(height_reg, MAX_H);
      cw = w >> shift_h;
      ch = h >> shift_v;
      pixels_taken++;
      fold(PLANE_Y, pix.luma);
      if (col < cw && row < ch) begin
        fold(PLANE_U, pix.cb_sample);
        fold(PLANE_V, pix.cr_sample);
      end
      // row and frame end on reaching or passing the current size
      last = 1'b0;
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          row  = 0;
          last = 1'b1;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      if (!last) return;
      r.frame_number = frame_no;
      r.min_y  = 8'(min_s[PLANE_Y]);
      r.mean_y = mean_fix(sum_s[PLANE_Y], 64'(w) * 64'(h));
      r.max_y  = 8'(max_s[PLANE_Y]);
      r.min_u  = 8'(min_s[PLANE_U]);
      r.mean_u = mean_fix(sum_s[PLANE_U], 64'(cw) * 64'(ch));
      r.max_u  = 8'(max_s[PLANE_U]);
      r.min_v  = 8'(min_s[PLANE_V]);
      r.mean_v = mean_fix(sum_s[PLANE_V], 64'(cw) * 64'(ch));
      r.max_v  = 8'(max_s[PLANE_V]);
      stats_due.push_back(r);
      frame_no++;
      clear_planes();
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(logic [31:0] frame, string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        log_mismatch($sformatf("frame %0d %s got %0h expected %0h", frame, name, got, want));
    endtask

    task check_frame(yfps_result_t got);
      yfps_result_t want;
      if (stats_due.size() == 0) begin
        log_mismatch($sformatf("result for frame %0d with none pending", got.frame_number));
        return;
      end
      want = stats_due.pop_front();
      frames_checked++;
      check_field(want.frame_number, "frame_number", got.frame_number, want.frame_number);
      check_field(want.frame_number, "min_y", got.min_y, want.min_y);
      check_field(want.frame_number, "mean_y", got.mean_y, want.mean_y);
      check_field(want.frame_number, "max_y", got.max_y, want.max_y);
      check_field(want.frame_number, "min_u", got.min_u, want.min_u);
      check_field(want.frame_number, "mean_u", got.mean_u, want.mean_u);
      check_field(want.frame_number, "max_u", got.max_u, want.max_u);
      check_field(want.frame_number, "min_v", got.min_v, want.min_v);
      check_field(want.frame_number, "mean_v", got.mean_v, want.mean_v);
      check_field(want.frame_number, "max_v", got.max_v, want.max_v);
    endtask
  endclass

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               push    = 1'b0;
  logic               full;
  yfps_pixel_t        in_data = '0;
  logic               empty;
  logic               pop     = 1'b0;
  yfps_result_t       out_data;

  frame_stats_board board;
  bit               idling_on = 1'b1;
  int unsigned      rx_stall;
  int unsigned      settings_done = 0;

  yuv_frame_plane_statistics_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check every result taken, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      rx_stall = 0;
    end else begin
      if (pop && !empty) board.check_frame(out_data);
      if (rx_stall != 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic yfps_pixel_t px(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    yfps_pixel_t p;
    p.luma      = y;
    p.cb_sample = u;
    p.cr_sample = v;
    return p;
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(9, 24);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic send_pixel(input yfps_pixel_t pix);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= pix;
    do @(posedge clk); while (full);
    board.take_pixel(pix);
  endtask

  task automatic send_run(input int unsigned n);
    repeat (n) send_pixel(px(pick_sample(), pick_sample(), pick_sample()));
  endtask

  // hold the input, let every pending frame drain, then give the divider time to go idle
  task automatic settle();
    push <= 1'b0;
    while (board.stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit is_write, input yfps_reg_e idx, input int unsigned wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // settle, read back the previous setting, then write all four registers back to back
  task automatic configure(input int unsigned w, input int unsigned h, input bit sh,
                           input bit sv);
    logic [PDATA_W-1:0] rd;
    int unsigned        vals [4];
    yfps_reg_e          idx;
    settle();
    vals = '{w, h, sh, sv};
    for (int i = 0; i < 4; i++) begin
      idx = yfps_reg_e'(i);
      apb_xfer(1'b0, idx, 0, rd);
      if (rd !== PDATA_W'(board.reg_value(idx)))
        board.log_mismatch($sformatf("%s read %0h expected %0h", idx.name(), rd,
                                     board.reg_value(idx)));
    end
    for (int i = 0; i < 4; i++) begin
      idx = yfps_reg_e'(i);
      apb_xfer(1'b1, idx, vals[i], rd);
      board.write_reg(idx, vals[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_done++;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned per_frame;
    int unsigned n;
    int unsigned n_rand;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sample extremes, full chroma plane
    configure(2, 2, 1'b0, 1'b0);
    send_pixel(px(8'h00, 8'hFF, 8'h00));
    send_pixel(px(8'hFF, 8'h00, 8'hFF));
    send_pixel(px(8'hFF, 8'hFF, 8'h00));
    send_pixel(px(8'h00, 8'h00, 8'hFF));
    // zero width taken as one, chroma plane empty
    configure(0, 3, 1'b1, 1'b0);
    send_pixel(px(8'd7, 8'hFF, 8'h00));
    send_pixel(px(8'd200, 8'h00, 8'hFF));
    send_pixel(px(8'd13, 8'd128, 8'd128));
    // one-pixel frames back to back to fill the frame queue
    configure(1, 0, 1'b0, 1'b0);
    send_pixel(px(8'hFF, 8'hFF, 8'hFF));
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'd128, 8'd127, 8'd1));
    // shrink the width part way through a frame
    configure(4, 3, 1'b1, 1'b1);
    send_run(6);
    configure(2, 3, 1'b1, 1'b1);
    send_run(3);

    // random small frames, sometimes leaving one open across a new setting
    n_rand = 0;
    while (n_rand < 380) begin
      if (n_rand >= 300) idling_on = 1'b0;
      w = pick_size();
      h = pick_size();
      configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      per_frame = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      n = per_frame * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, per_frame);
      if (n > 400 - n_rand) n = 400 - n_rand;
      send_run(n);
      n_rand += n;
    end

    settle();
    $display("Covered %0d pixels, %0d frame results and %0d register settings,",
             board.pixels_taken, board.frames_checked, settings_done);
    $display("with extreme samples, empty chroma, one-pixel frames and a mid-frame resize.");
    if (board.mismatches == 0 && board.stats_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout: %0d frame results still pending", board.stats_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
sv/yfps_pkg.sv
sv/yfps_front.sv
sv/yfps_queue.sv
sv/yfps_back.sv
sv/yuv_frame_plane_statistics_unit.sv
verif/tb_yuv_frame_plane_statistics_unit.sv
